// ----- hdl/lrcm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrcm_pkg
// shared widths, constants and types of the longest run center unit
// ----------------------------------------------------------------------------
package lrcm_pkg;

  localparam int PIXEL_W  = 8;
  localparam int CENTER_W = 10;
  localparam int RUN_W    = 11;

  localparam logic [PIXEL_W-1:0] TRACK_LEVEL = 8'd255;

  typedef logic [PIXEL_W-1:0]  pixel_t;
  typedef logic [CENTER_W-1:0] center_t;
  typedef logic [RUN_W-1:0]    run_len_t;

  typedef struct packed {
    center_t  center;
    run_len_t run_length;
  } row_result_t;

endpackage
`default_nettype wire

// ----- hdl/lrcm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrcm channel interfaces
// valid/ready channels for pixel input and row result output
// ----------------------------------------------------------------------------
interface lrcm_in_if;
  logic                 valid;
  logic                 ready;
  lrcm_pkg::pixel_t     pixel_value;
  logic                 row_end;

  modport source (output valid, output pixel_value, output row_end, input ready);
  modport sink   (input valid, input pixel_value, input row_end, output ready);
endinterface

interface lrcm_out_if;
  logic                 valid;
  logic                 ready;
  lrcm_pkg::center_t    raw_center;
  lrcm_pkg::center_t    filtered_center;
  lrcm_pkg::run_len_t   run_length;

  modport source (output valid, output raw_center, output filtered_center,
                  output run_length, input ready);
  modport sink   (input valid, input raw_center, input filtered_center,
                  input run_length, output ready);
endinterface
`default_nettype wire

// ----- hdl/row_longest_run_center_median_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// row_longest_run_center_median_unit
// longest bright run center per row with a median filter over recent rows
// ----------------------------------------------------------------------------
// result: registered when the transaction carrying row_end leaves the input register
// throughput: one pixel per cycle, input register then result register
// a full result register stalls only pixels that end a row
// reset clears row state, the center ring to zero and all valid flags
module row_longest_run_center_median_unit #(
  parameter int ROW_WIDTH     = 1024,
  parameter int HISTORY_DEPTH = 4
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lrcm_in_if.sink    in_chan,
  lrcm_out_if.source out_chan
);
  import lrcm_pkg::*;

  logic        a_valid_r, a_valid_nxt;
  pixel_t      a_pixel_r;
  logic        a_row_end_r;
  logic        a_move;
  logic        in_take;
  logic        out_load;
  logic        out_valid_r, out_valid_nxt;
  center_t     out_raw_r, out_filt_r;
  run_len_t    out_len_r;
  row_result_t row_res;
  center_t     median;

  assign a_move   = a_valid_r && (!a_row_end_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !a_valid_r || a_move;
  assign in_take  = in_chan.valid && in_chan.ready;
  assign out_load = a_move && a_row_end_r;

  lrcm_run_tracker #(
    .ROW_WIDTH (ROW_WIDTH)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (a_move),
    .pixel   (a_pixel_r),
    .row_end (a_row_end_r),
    .result  (row_res)
  );

  lrcm_median_ring #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (out_load),
    .center (row_res.center),
    .median (median)
  );

  always_comb begin
    a_valid_nxt = in_take ? 1'b1 : (a_move ? 1'b0 : a_valid_r);
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_pixel_r   <= in_chan.pixel_value;
      a_row_end_r <= in_chan.row_end;
    end
    if (out_load) begin
      out_raw_r  <= row_res.center;
      out_filt_r <= median;
      out_len_r  <= row_res.run_length;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.raw_center      = out_raw_r;
  assign out_chan.filtered_center = out_filt_r;
  assign out_chan.run_length      = out_len_r;

  a_stall_only_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_move |-> a_row_end_r && out_valid_r && !out_chan.ready)
    else $error("pixel stage stalled without a blocked result");

  a_row_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("row end transaction produced no result");

  a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> a_valid_r)
    else $error("accepted transaction lost from input stage");

endmodule
`default_nettype wire

// ----- hdl/lrcm_run_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrcm_run_tracker
// follows bright runs along a row and forms the longest run's center at row end
// ----------------------------------------------------------------------------
module lrcm_run_tracker #(
  parameter int ROW_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire lrcm_pkg::pixel_t      pixel,
  input  wire logic                  row_end,
  output      lrcm_pkg::row_result_t result
);
  import lrcm_pkg::*;

  localparam int COL_W = $clog2(ROW_WIDTH);
  localparam int LEN_W = $clog2(ROW_WIDTH + 1);
  localparam int SUM_W = LEN_W + 1;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] cur_start_r, cur_start_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [COL_W-1:0] best_start_r, best_start_nxt;
  logic [LEN_W-1:0] best_len_r, best_len_nxt;
  logic             past_edge_r, past_edge_nxt;

  logic [COL_W-1:0] t_cur_start, t_best_start, fin_start;
  logic [LEN_W-1:0] t_cur_len, t_best_len, fin_len;
  logic [SUM_W-1:0] center_sum;
  logic             bright;

  always_comb begin
    bright        = (pixel == TRACK_LEVEL);
    t_cur_start   = cur_start_r;
    t_cur_len     = cur_len_r;
    t_best_start  = best_start_r;
    t_best_len    = best_len_r;
    col_nxt       = col_r;
    past_edge_nxt = past_edge_r;

    if (!past_edge_r) begin
      if (bright) begin
        if (cur_len_r == '0) begin
          t_cur_start = col_r;
        end
        t_cur_len = cur_len_r + 1'b1;
      end else begin
        if (cur_len_r > best_len_r) begin
          t_best_start = cur_start_r;
          t_best_len   = cur_len_r;
        end
        t_cur_len = '0;
      end
      if (col_r == COL_W'(ROW_WIDTH - 1)) begin
        past_edge_nxt = 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end

    // close the open run at row end
    fin_start = t_best_start;
    fin_len   = t_best_len;
    if (t_cur_len > t_best_len) begin
      fin_start = t_cur_start;
      fin_len   = t_cur_len;
    end
    center_sum        = SUM_W'(fin_start) + SUM_W'(fin_len >> 1);
    result.center     = CENTER_W'(center_sum);
    result.run_length = RUN_W'(fin_len);

    if (row_end) begin
      col_nxt        = '0;
      cur_start_nxt  = '0;
      cur_len_nxt    = '0;
      best_start_nxt = '0;
      best_len_nxt   = '0;
      past_edge_nxt  = 1'b0;
    end else begin
      cur_start_nxt  = t_cur_start;
      cur_len_nxt    = t_cur_len;
      best_start_nxt = t_best_start;
      best_len_nxt   = t_best_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      cur_start_r  <= '0;
      cur_len_r    <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
      past_edge_r  <= 1'b0;
    end else if (step) begin
      col_r        <= col_nxt;
      cur_start_r  <= cur_start_nxt;
      cur_len_r    <= cur_len_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      past_edge_r  <= past_edge_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lrcm_median_ring.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrcm_median_ring
// ring of recent centers with a rank based median of the updated ring
// ----------------------------------------------------------------------------
module lrcm_median_ring #(
  parameter int HISTORY_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lrcm_pkg::center_t center,
  output      lrcm_pkg::center_t median
);
  import lrcm_pkg::*;

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int LO    = (HISTORY_DEPTH - 1) / 2;
  localparam int HI    = HISTORY_DEPTH / 2;

  center_t          hist_r   [HISTORY_DEPTH];
  center_t          hist_nxt [HISTORY_DEPTH];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] rank     [HISTORY_DEPTH];
  center_t          lo_val, hi_val;
  logic [CENTER_W:0] mid_sum;

  always_comb begin
    idx_nxt = (idx_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : idx_r + 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hist_nxt[i] = (idx_nxt == IDX_W'(i)) ? center : hist_r[i];
    end

    // unique rank of each entry, ties broken by slot
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        if ((j != i) && ((hist_nxt[j] < hist_nxt[i]) ||
                         ((hist_nxt[j] == hist_nxt[i]) && (j < i)))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end

    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (rank[i] == IDX_W'(LO)) begin
        lo_val = hist_nxt[i];
      end
      if (rank[i] == IDX_W'(HI)) begin
        hi_val = hist_nxt[i];
      end
    end
    mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
    median  = mid_sum[CENTER_W:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (push) begin
      idx_r <= idx_nxt;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/row_center_checker.sv -----
// ----------------------------------------------------------------------------
// row_center_checker
// watches the pixel and row result channels, tracks the longest bright run of
// each row, the ring of recent centers and its median, and compares every
// row result transaction with the oldest predicted row
// ----------------------------------------------------------------------------
module row_center_checker
  import lrcm_pkg::*;
#(
  parameter int ROW_WIDTH     = 1024,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  lrcm_in_if   pix_mon,
  lrcm_out_if  row_mon,
  output int   fail_count,
  output int   rows_pending
);

  typedef struct {
    center_t  raw_center;
    center_t  filtered_center;
    run_len_t run_length;
  } row_summary_t;

  row_summary_t predicted_rows[$];

  logic [CENTER_W-1:0] col_idx;
  logic [CENTER_W-1:0] run_start;
  run_len_t            run_len;
  logic [CENTER_W-1:0] best_start;
  run_len_t            best_len;
  logic                past_edge;
  center_t             center_ring[HISTORY_DEPTH];
  int                  ring_idx;

  always @(posedge clk) begin : row_tracker
    row_summary_t        seen;
    row_summary_t        want;
    center_t             sorted[HISTORY_DEPTH];
    center_t             swap;
    logic [CENTER_W:0]   center_sum;
    logic [CENTER_W:0]   mid_sum;
    if (!rst_n) begin
      predicted_rows.delete();
      col_idx    = '0;
      run_start  = '0;
      run_len    = '0;
      best_start = '0;
      best_len   = '0;
      past_edge  = 1'b0;
      ring_idx   = 0;
      for (int i = 0; i < HISTORY_DEPTH; i++) center_ring[i] = '0;
    end else begin
      // result side first, so a transaction never meets its own prediction
      if (row_mon.valid && row_mon.ready) begin
        seen.raw_center      = row_mon.raw_center;
        seen.filtered_center = row_mon.filtered_center;
        seen.run_length      = row_mon.run_length;
        if (predicted_rows.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected row result: raw %0d filtered %0d length %0d",
                     $realtime, seen.raw_center, seen.filtered_center, seen.run_length);
          fail_count++;
        end else begin
          want = predicted_rows.pop_front();
          if (seen.raw_center !== want.raw_center ||
              seen.filtered_center !== want.filtered_center ||
              seen.run_length !== want.run_length) begin
            if (fail_count < 10)
              $display("[%0t] row mismatch: raw exp %0d act %0d, ",
                       $realtime, want.raw_center, seen.raw_center,
                       "filtered exp %0d act %0d, ",
                       want.filtered_center, seen.filtered_center,
                       "length exp %0d act %0d",
                       want.run_length, seen.run_length);
            fail_count++;
          end
        end
      end

      if (pix_mon.valid && pix_mon.ready) begin
        if (!past_edge) begin
          if (pix_mon.pixel_value == TRACK_LEVEL) begin
            if (run_len == 0) run_start = col_idx;
            run_len = run_len + 1'b1;
          end else begin
            if (run_len > best_len) begin
              best_start = run_start;
              best_len   = run_len;
            end
            run_len = '0;
          end
          if (col_idx == ROW_WIDTH - 1) past_edge = 1'b1;
          else col_idx = col_idx + 1'b1;
        end
        if (pix_mon.row_end) begin
          if (run_len > best_len) begin
            best_start = run_start;
            best_len   = run_len;
          end
          center_sum = {1'b0, best_start} + (best_len >> 1);
          ring_idx = (ring_idx + 1) % HISTORY_DEPTH;
          center_ring[ring_idx] = center_sum[CENTER_W-1:0];
          for (int i = 0; i < HISTORY_DEPTH; i++) sorted[i] = center_ring[i];
          for (int i = 0; i < HISTORY_DEPTH - 1; i++)
            for (int j = 0; j < HISTORY_DEPTH - 1 - i; j++)
              if (sorted[j] > sorted[j+1]) begin
                swap        = sorted[j];
                sorted[j]   = sorted[j+1];
                sorted[j+1] = swap;
              end
          if (HISTORY_DEPTH % 2 == 0) begin
            mid_sum = {1'b0, sorted[(HISTORY_DEPTH-1)/2]} +
                      {1'b0, sorted[(HISTORY_DEPTH-1)/2 + 1]};
            want.filtered_center = mid_sum[CENTER_W:1];
          end else begin
            want.filtered_center = sorted[HISTORY_DEPTH/2];
          end
          want.raw_center = center_sum[CENTER_W-1:0];
          want.run_length = best_len;
          predicted_rows.push_back(want);
          col_idx    = '0;
          run_start  = '0;
          run_len    = '0;
          best_start = '0;
          best_len   = '0;
          past_edge  = 1'b0;
        end
      end
    end
    rows_pending = predicted_rows.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// drives image rows into the longest run center unit: short directed rows for
// empty rows, ties, runs closed by the row end and non-track levels, then
// random rows in three phases with different sender and receiver idling; the checker
// predicts and compares the results
// ----------------------------------------------------------------------------
module tb;
  import lrcm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 624;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   fail_count;
  int   rows_pending;

  lrcm_in_if  pix_chan ();
  lrcm_out_if row_chan ();

  row_longest_run_center_median_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_chan),
    .out_chan (row_chan)
  );

  row_center_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_mon      (pix_chan),
    .row_mon      (row_chan),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    row_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** row_longest_run_center_median_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_t value, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_chan.valid <= 1'b0;
      @(negedge clk);
    end
    pix_chan.valid       <= 1'b1;
    pix_chan.pixel_value <= value;
    pix_chan.row_end     <= last;
    @(posedge clk);
    while (!pix_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_row(input pixel_t pixels[$]);
    for (int i = 0; i < pixels.size(); i++) send_pixel(pixels[i], i == pixels.size() - 1);
  endtask

  task automatic send_random_row(output int row_len);
    pixel_t row[$];
    int     seg;
    bit     bright;
    bit     noisy;
    row_len = ($urandom_range(9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
    noisy   = ($urandom_range(9) == 0);
    while (row.size() < row_len) begin
      seg    = $urandom_range(1, 6);
      bright = 1'($urandom_range(1));
      repeat (seg)
        if (row.size() < row_len)
          row.push_back(noisy  ? pixel_t'($urandom_range(255)) :
                        bright ? TRACK_LEVEL : pixel_t'($urandom_range(254)));
    end
    send_row(row);
  endtask

  initial begin
    int     sent;
    int     row_len;
    rst_n                = 1'b0;
    pix_chan.valid       = 1'b0;
    pix_chan.pixel_value = '0;
    pix_chan.row_end     = 1'b0;
    src_idle_pct         = 26;
    snk_idle_pct         = 62;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single bright pixel, single dark pixel
    send_row('{TRACK_LEVEL});
    send_row('{8'd0});
    // non-track levels only, no run
    send_row('{8'd254, 8'd127, 8'd128, 8'd1});
    // equal runs, earliest wins
    send_row('{TRACK_LEVEL, 8'd0, TRACK_LEVEL});
    send_row('{TRACK_LEVEL, TRACK_LEVEL, 8'd0, 8'd1, TRACK_LEVEL, TRACK_LEVEL});
    // longest run closed by the row end
    send_row('{8'd0, TRACK_LEVEL, TRACK_LEVEL, 8'd0, TRACK_LEVEL, TRACK_LEVEL, TRACK_LEVEL});
    send_row('{8'd200, TRACK_LEVEL, 8'd255, 8'd64});

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 62 : 0;
      snk_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 26 : 0;
      sent = 0;
      while (sent < RANDOM_PIXELS / 3) begin
        send_random_row(row_len);
        sent += row_len;
      end
    end
    pix_chan.valid <= 1'b0;

    while (rows_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("** row_longest_run_center_median_unit: PASSED **");
    end else begin
      $display("** row_longest_run_center_median_unit: FAILED **");
    end
    $finish;
  end

endmodule
